>>> hdl/salc_pkg.sv
// shared constants, codes and helpers for the set-associative lru cache classifier
package salc_pkg;

   // request field widths
   localparam int OP_W        = 2;
   localparam int ADDR_FIELD_W = 64;
   localparam int COUNT_W     = 32;

   // configuration port
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int SET_CFG_W   = 3;
   localparam int OFFSET_CFG_W = 6;
   localparam int WAYS_CFG_W  = 4;

   // shift amount for address split, covers offset plus set bits
   localparam int SHIFT_W     = 7;

   // access kinds
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   // saturating counter increment
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == {COUNT_W{1'b1}}) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
      return r;
   endfunction

endpackage

>>> hdl/set_assoc_lru_cache_classifier_unit.sv
// set-associative cache classifier with lru replacement, top level
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_stall      req_op, req_address
//   rsp       out         rsp_valid / rsp_stall      rsp_hits_now .. rsp_total_evictions
//   csr       in          csr_write                  csr_index, csr_wdata
//
// Between acceptances a load or store reads the set row, scans its ways once
// with one tag compare per cycle, updates and writes the row back; a modify
// scans and updates twice before the write, and an unused op code goes straight to the result.
// Reset is synchronous and clears the per-set written bits, so lines read empty.
// A result waits in the output register under rsp_stall while the next
// request is accepted and worked on; req_stall is high while an access runs.
module set_assoc_lru_cache_classifier_unit #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [salc_pkg::OP_W-1:0]           req_op,
   input  logic [salc_pkg::ADDR_FIELD_W-1:0]   req_address,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_hits_now,
   output logic                                rsp_missed_now,
   output logic                                rsp_evicted_now,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_total_hits,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_total_misses,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_total_evictions,
   // configuration port
   input  logic                                csr_write,
   input  logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_ROWS = 1 << SET_W;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SHIFT_W_LOCAL = salc_pkg::SHIFT_W;

   typedef struct packed {
      logic                  valid;
      logic [WAY_W-1:0]      rank;
      logic [ADDR_WIDTH-1:0] tag;
   } line_type;

   localparam int ROW_W = $bits(line_type) * MAX_WAYS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_SCAN,
      S_UPDATE,
      S_WRITE,
      S_DONE
   } state_type;

   // unpack a ram word into lines
   function automatic line_type [MAX_WAYS-1:0] line_type_row(input logic [ROW_W-1:0] w);
      line_type [MAX_WAYS-1:0] r;
      r = w;
      return r;
   endfunction

   // control registers
   state_type                          state_ff, state_in;
   logic                               pass_ff, pass_in;
   logic [WAY_W-1:0]                   cnt_ff, cnt_in;
   logic [NUM_ROWS-1:0]                written_ff, written_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [salc_pkg::SET_CFG_W-1:0]     cfg_set_bits_ff, cfg_set_bits_in;
   logic [salc_pkg::OFFSET_CFG_W-1:0]  cfg_offset_bits_ff, cfg_offset_bits_in;
   logic [salc_pkg::WAYS_CFG_W-1:0]    cfg_ways_ff, cfg_ways_in;
   logic [salc_pkg::COUNT_W-1:0]       total_hits_ff, total_hits_in;
   logic [salc_pkg::COUNT_W-1:0]       total_misses_ff, total_misses_in;
   logic [salc_pkg::COUNT_W-1:0]       total_evictions_ff, total_evictions_in;

   // working registers
   logic [salc_pkg::OP_W-1:0]          op_ff, op_in;
   logic [SET_W-1:0]                   set_ff, set_in;
   logic [ADDR_WIDTH-1:0]              tag_ff, tag_in;
   line_type [MAX_WAYS-1:0]            row_ff, row_in;
   logic                               hit_found_ff, hit_found_in;
   logic [WAY_W-1:0]                   hit_way_ff, hit_way_in;
   logic                               inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]                   inv_way_ff, inv_way_in;
   logic [WAY_W-1:0]                   min_way_ff, min_way_in;
   logic [WAY_W-1:0]                   min_rank_ff, min_rank_in;
   logic [1:0]                         hits_now_ff, hits_now_in;
   logic                               missed_now_ff, missed_now_in;
   logic                               evicted_now_ff, evicted_now_in;

   // result registers
   logic [1:0]                         rsp_hits_now_ff, rsp_hits_now_in;
   logic                               rsp_missed_now_ff, rsp_missed_now_in;
   logic                               rsp_evicted_now_ff, rsp_evicted_now_in;
   logic [salc_pkg::COUNT_W-1:0]       rsp_total_hits_ff, rsp_total_hits_in;
   logic [salc_pkg::COUNT_W-1:0]       rsp_total_misses_ff, rsp_total_misses_in;
   logic [salc_pkg::COUNT_W-1:0]       rsp_total_evictions_ff, rsp_total_evictions_in;

   // combinational helpers
   logic [ADDR_WIDTH-1:0]              addr_cut;
   logic [SHIFT_W_LOCAL-1:0]           s_amt;
   logic [SHIFT_W_LOCAL-1:0]           b_amt;
   logic [SHIFT_W_LOCAL-1:0]           sb_amt;
   logic [ADDR_WIDTH-1:0]              addr_shifted;
   logic [SET_W-1:0]                   set_mask;
   logic [SET_W-1:0]                   acc_set;
   logic [ADDR_WIDTH-1:0]              acc_tag;
   logic [WAY_W-1:0]                   way_last;
   line_type                           cur_line;
   logic [WAY_W-1:0]                   tgt_way;
   logic [WAY_W-1:0]                   old_rank;
   logic                               is_hit;
   logic                               is_evict;
   logic [ROW_W-1:0]                   ram_rd_data;

   // set-row storage: all ways of one set in one word
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_WRITE),
      .wr_addr (set_ff),
      .wr_data (row_ff),
      .rd_en   (state_ff == S_READ),
      .rd_addr (set_ff),
      .rd_data (ram_rd_data)
   );

   // address split into set index and tag
   always_comb begin
      addr_cut     = req_address[ADDR_WIDTH-1:0];
      s_amt        = (cfg_set_bits_ff > MAX_SET_BITS) ? SHIFT_W_LOCAL'(MAX_SET_BITS)
                                                      : SHIFT_W_LOCAL'(cfg_set_bits_ff);
      b_amt        = SHIFT_W_LOCAL'(cfg_offset_bits_ff);
      sb_amt       = s_amt + b_amt;
      addr_shifted = addr_cut >> b_amt;
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (SHIFT_W_LOCAL'(i) < s_amt);
      end
      if (b_amt >= ADDR_WIDTH) begin
         acc_set = '0;
      end else begin
         acc_set = addr_shifted[SET_W-1:0] & set_mask;
      end
      if ((b_amt >= ADDR_WIDTH) || (sb_amt >= ADDR_WIDTH)) begin
         acc_tag = '0;
      end else begin
         acc_tag = addr_cut >> sb_amt;
      end
   end

   // effective associativity minus one
   always_comb begin
      if (cfg_ways_ff == '0) begin
         way_last = '0;
      end else if (cfg_ways_ff > MAX_WAYS) begin
         way_last = WAY_W'(MAX_WAYS - 1);
      end else begin
         way_last = WAY_W'(cfg_ways_ff - 4'd1);
      end
   end

   // replacement decision for the update step
   always_comb begin
      cur_line = row_ff[cnt_ff];
      is_hit   = hit_found_ff;
      is_evict = !hit_found_ff && !inv_found_ff;
      if (hit_found_ff) begin
         tgt_way = hit_way_ff;
      end else if (inv_found_ff) begin
         tgt_way = inv_way_ff;
      end else begin
         tgt_way = min_way_ff;
      end
      old_rank = row_ff[tgt_way].rank;
   end

   // sequencer next state
   always_comb begin
      state_in               = state_ff;
      pass_in                = pass_ff;
      cnt_in                 = cnt_ff;
      written_in             = written_ff;
      cfg_set_bits_in        = cfg_set_bits_ff;
      cfg_offset_bits_in     = cfg_offset_bits_ff;
      cfg_ways_in            = cfg_ways_ff;
      total_hits_in          = total_hits_ff;
      total_misses_in        = total_misses_ff;
      total_evictions_in     = total_evictions_ff;
      op_in                  = op_ff;
      set_in                 = set_ff;
      tag_in                 = tag_ff;
      row_in                 = row_ff;
      hit_found_in           = hit_found_ff;
      hit_way_in             = hit_way_ff;
      inv_found_in           = inv_found_ff;
      inv_way_in             = inv_way_ff;
      min_way_in             = min_way_ff;
      min_rank_in            = min_rank_ff;
      hits_now_in            = hits_now_ff;
      missed_now_in          = missed_now_ff;
      evicted_now_in         = evicted_now_ff;
      rsp_hits_now_in        = rsp_hits_now_ff;
      rsp_missed_now_in      = rsp_missed_now_ff;
      rsp_evicted_now_in     = rsp_evicted_now_ff;
      rsp_total_hits_in      = rsp_total_hits_ff;
      rsp_total_misses_in    = rsp_total_misses_ff;
      rsp_total_evictions_in = rsp_total_evictions_ff;

      // result leaves when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // configuration writes
      if (csr_write) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:    cfg_set_bits_in    = csr_wdata[salc_pkg::SET_CFG_W-1:0];
            salc_pkg::CSR_OFFSET_BITS: cfg_offset_bits_in = csr_wdata;
            salc_pkg::CSR_WAYS:        cfg_ways_in        = csr_wdata[salc_pkg::WAYS_CFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         // accept a request and split its address
         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_op;
               set_in         = acc_set;
               tag_in         = acc_tag;
               pass_in        = 1'b0;
               hits_now_in    = 2'd0;
               missed_now_in  = 1'b0;
               evicted_now_in = 1'b0;
               if (req_op inside {salc_pkg::OP_LOAD, salc_pkg::OP_STORE,
                                  salc_pkg::OP_MODIFY}) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         // ram read issued
         S_READ: begin
            state_in = S_LOAD;
         end
         // capture the set row, never-written rows read as empty
         S_LOAD: begin
            row_in       = written_ff[set_ff] ? line_type_row(ram_rd_data) : '0;
            cnt_in       = '0;
            hit_found_in = 1'b0;
            inv_found_in = 1'b0;
            state_in     = S_SCAN;
         end
         // one way per cycle through the shared tag comparator
         S_SCAN: begin
            if (!hit_found_ff && cur_line.valid && (cur_line.tag == tag_ff)) begin
               hit_found_in = 1'b1;
               hit_way_in   = cnt_ff;
            end
            if (!inv_found_ff && !cur_line.valid) begin
               inv_found_in = 1'b1;
               inv_way_in   = cnt_ff;
            end
            if ((cnt_ff == '0) || (cur_line.rank < min_rank_ff)) begin
               min_way_in  = cnt_ff;
               min_rank_in = cur_line.rank;
            end
            if (cnt_ff == way_last) begin
               state_in = S_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // fill or touch the chosen way and count the outcome; a modify's first pass then starts its second scan
         S_UPDATE: begin
            for (int i = 0; i < MAX_WAYS; i++) begin
               if ((WAY_W'(i) <= way_last) && (WAY_W'(i) != tgt_way)
                   && (row_ff[i].rank > old_rank)) begin
                  row_in[i].rank = row_ff[i].rank - 1'b1;
               end
            end
            row_in[tgt_way].rank = way_last;
            if (is_hit) begin
               total_hits_in = salc_pkg::sat_inc(total_hits_ff);
               hits_now_in   = hits_now_ff + 2'd1;
            end else begin
               row_in[tgt_way].valid = 1'b1;
               row_in[tgt_way].tag   = tag_ff;
               total_misses_in       = salc_pkg::sat_inc(total_misses_ff);
               if (!pass_ff) begin
                  missed_now_in = 1'b1;
               end
               if (is_evict) begin
                  total_evictions_in = salc_pkg::sat_inc(total_evictions_ff);
                  evicted_now_in     = 1'b1;
               end
            end
            if ((op_ff == salc_pkg::OP_MODIFY) && !pass_ff) begin
               pass_in      = 1'b1;
               cnt_in       = '0;
               hit_found_in = 1'b0;
               inv_found_in = 1'b0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_WRITE;
            end
         end
         // write the row back
         S_WRITE: begin
            written_in[set_ff] = 1'b1;
            state_in           = S_DONE;
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_hits_now_in        = hits_now_ff;
               rsp_missed_now_in      = missed_now_ff;
               rsp_evicted_now_in     = evicted_now_ff;
               rsp_total_hits_in      = total_hits_ff;
               rsp_total_misses_in    = total_misses_ff;
               rsp_total_evictions_in = total_evictions_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         pass_ff            <= 1'b0;
         cnt_ff             <= '0;
         written_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
         cfg_set_bits_ff    <= '0;
         cfg_offset_bits_ff <= '0;
         cfg_ways_ff        <= salc_pkg::WAYS_CFG_W'(1);
         total_hits_ff      <= '0;
         total_misses_ff    <= '0;
         total_evictions_ff <= '0;
      end else begin
         state_ff           <= state_in;
         pass_ff            <= pass_in;
         cnt_ff             <= cnt_in;
         written_ff         <= written_in;
         rsp_valid_ff       <= rsp_valid_in;
         cfg_set_bits_ff    <= cfg_set_bits_in;
         cfg_offset_bits_ff <= cfg_offset_bits_in;
         cfg_ways_ff        <= cfg_ways_in;
         total_hits_ff      <= total_hits_in;
         total_misses_ff    <= total_misses_in;
         total_evictions_ff <= total_evictions_in;
      end
      op_ff                  <= op_in;
      set_ff                 <= set_in;
      tag_ff                 <= tag_in;
      row_ff                 <= row_in;
      hit_found_ff           <= hit_found_in;
      hit_way_ff             <= hit_way_in;
      inv_found_ff           <= inv_found_in;
      inv_way_ff             <= inv_way_in;
      min_way_ff             <= min_way_in;
      min_rank_ff            <= min_rank_in;
      hits_now_ff            <= hits_now_in;
      missed_now_ff          <= missed_now_in;
      evicted_now_ff         <= evicted_now_in;
      rsp_hits_now_ff        <= rsp_hits_now_in;
      rsp_missed_now_ff      <= rsp_missed_now_in;
      rsp_evicted_now_ff     <= rsp_evicted_now_in;
      rsp_total_hits_ff      <= rsp_total_hits_in;
      rsp_total_misses_ff    <= rsp_total_misses_in;
      rsp_total_evictions_ff <= rsp_total_evictions_in;
   end

   // ports
   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hits_now        = rsp_hits_now_ff;
   assign rsp_missed_now      = rsp_missed_now_ff;
   assign rsp_evicted_now     = rsp_evicted_now_ff;
   assign rsp_total_hits      = rsp_total_hits_ff;
   assign rsp_total_misses    = rsp_total_misses_ff;
   assign rsp_total_evictions = rsp_total_evictions_ff;

endmodule

>>> hdl/salc_ram.sv
// generic single-write, single-read ram with registered read data
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/salc_scoreboard_pkg.sv
// scoreboard for the lru cache classifier: cache state predictor and expected result store
package salc_scoreboard_pkg;

   localparam int TB_MAX_SET_BITS = 6;
   localparam int TB_MAX_WAYS     = 8;
   localparam int TB_SETS         = 1 << TB_MAX_SET_BITS;

   // op code that performs no access
   localparam logic [salc_pkg::OP_W-1:0] OP_NONE = 2'd3;

   typedef struct {
      logic [1:0]                   hits_now;
      logic                         missed_now;
      logic                         evicted_now;
      logic [salc_pkg::COUNT_W-1:0] total_hits;
      logic [salc_pkg::COUNT_W-1:0] total_misses;
      logic [salc_pkg::COUNT_W-1:0] total_evictions;
   } cache_outcome_type;

   class cache_scoreboard_type;
      // predicted cache contents
      bit                           way_valid [TB_SETS][TB_MAX_WAYS];
      bit [63:0]                    way_tag   [TB_SETS][TB_MAX_WAYS];
      bit [2:0]                     way_rank  [TB_SETS][TB_MAX_WAYS];
      bit [salc_pkg::COUNT_W-1:0]   pred_hits;
      bit [salc_pkg::COUNT_W-1:0]   pred_misses;
      bit [salc_pkg::COUNT_W-1:0]   pred_evictions;
      // configuration as written to the block
      bit [salc_pkg::SET_CFG_W-1:0]    cfg_set_bits;
      bit [salc_pkg::OFFSET_CFG_W-1:0] cfg_offset_bits;
      bit [salc_pkg::WAYS_CFG_W-1:0]   cfg_ways;
      cache_outcome_type            expected_outcomes[$];
      int                           mismatches;

      function new();
         cfg_ways = 1;
      endfunction

      function void set_config(bit [salc_pkg::SET_CFG_W-1:0] s,
                               bit [salc_pkg::OFFSET_CFG_W-1:0] b,
                               bit [salc_pkg::WAYS_CFG_W-1:0] w);
         cfg_set_bits    = s;
         cfg_offset_bits = b;
         cfg_ways        = w;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function bit [salc_pkg::COUNT_W-1:0] bump(bit [salc_pkg::COUNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // make a way most recently used, lines above its old rank move down
      function void promote(int set, int way, int ways);
         bit [2:0] old;
         old = way_rank[set][way];
         for (int i = 0; i < ways; i++) begin
            if (i != way && way_rank[set][i] > old) way_rank[set][i]--;
         end
         way_rank[set][way] = 3'(ways - 1);
      endfunction

      // one cache access, returns 1 on a hit
      function bit lookup(logic [63:0] addr, output bit evicted);
         int        ways, s, b, set, victim;
         bit [63:0] tag;
         evicted = 1'b0;
         ways = (cfg_ways == 0) ? 1 : (cfg_ways > TB_MAX_WAYS) ? TB_MAX_WAYS : int'(cfg_ways);
         s = (cfg_set_bits > TB_MAX_SET_BITS) ? TB_MAX_SET_BITS : int'(cfg_set_bits);
         b = cfg_offset_bits;
         // address split, fields past the top of the address read as zero
         if (b >= 64) begin
            set = 0;
            tag = '0;
         end else begin
            set = int'((addr >> b) & ((64'd1 << s) - 64'd1));
            tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
         end
         // lowest matching way wins
         for (int i = 0; i < ways; i++) begin
            if (way_valid[set][i] && way_tag[set][i] == tag) begin
               pred_hits = bump(pred_hits);
               promote(set, i, ways);
               return 1'b1;
            end
         end
         pred_misses = bump(pred_misses);
         // fill lowest invalid way, else evict lowest rank (lowest way on a tie)
         victim = ways;
         for (int i = 0; i < ways; i++) begin
            if (!way_valid[set][i]) begin
               victim = i;
               break;
            end
         end
         if (victim == ways) begin
            victim = 0;
            for (int i = 1; i < ways; i++) begin
               if (way_rank[set][i] < way_rank[set][victim]) victim = i;
            end
            pred_evictions = bump(pred_evictions);
            evicted = 1'b1;
         end
         way_valid[set][victim] = 1'b1;
         way_tag[set][victim]   = tag;
         promote(set, victim, ways);
         return 1'b0;
      endfunction

      // accepted request: predict its result
      function void note_access(logic [salc_pkg::OP_W-1:0] op, logic [63:0] addr);
         cache_outcome_type want;
         bit                hit;
         bit                ev;
         want = '{default: '0};
         case (op)
            salc_pkg::OP_LOAD, salc_pkg::OP_STORE, salc_pkg::OP_MODIFY: begin
               hit = lookup(addr, ev);
               want.hits_now    = 2'(hit);
               want.missed_now  = !hit;
               want.evicted_now = ev;
               // modify writes back to the same address
               if (op == salc_pkg::OP_MODIFY) begin
                  hit = lookup(addr, ev);
                  want.hits_now = want.hits_now + 2'(hit);
                  if (ev) want.evicted_now = 1'b1;
               end
            end
            default: ;
         endcase
         want.total_hits      = pred_hits;
         want.total_misses    = pred_misses;
         want.total_evictions = pred_evictions;
         expected_outcomes.push_back(want);
      endfunction

      function void compare_field(string field, logic [salc_pkg::COUNT_W-1:0] want,
                                  logic [salc_pkg::COUNT_W-1:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            mismatches++;
         end
      endfunction

      // accepted result: compare with the oldest prediction
      function void check_outcome(cache_outcome_type got);
         cache_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("hits_now", 32'(want.hits_now), 32'(got.hits_now));
         compare_field("missed_now", 32'(want.missed_now), 32'(got.missed_now));
         compare_field("evicted_now", 32'(want.evicted_now), 32'(got.evicted_now));
         compare_field("total_hits", want.total_hits, got.total_hits);
         compare_field("total_misses", want.total_misses, got.total_misses);
         compare_field("total_evictions", want.total_evictions, got.total_evictions);
      endfunction
   endclass

endpackage

>>> tb/tb.sv
// testbench top for the set-associative lru cache classifier
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_ACCESSES  = 200;
   localparam int DRAIN_CYCLES    = 30;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [salc_pkg::OP_W-1:0]         req_op = '0;
   logic [salc_pkg::ADDR_FIELD_W-1:0] req_address = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [1:0]                        rsp_hits_now;
   logic                              rsp_missed_now;
   logic                              rsp_evicted_now;
   logic [salc_pkg::COUNT_W-1:0]      rsp_total_hits;
   logic [salc_pkg::COUNT_W-1:0]      rsp_total_misses;
   logic [salc_pkg::COUNT_W-1:0]      rsp_total_evictions;
   logic                              csr_write = 1'b0;
   logic [salc_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [salc_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   salc_scoreboard_pkg::cache_scoreboard_type sb;
   bit                                quiet_phase;
   int                                n_requests;
   int                                n_settings;
   bit [salc_pkg::SET_CFG_W-1:0]      cur_set_bits;
   bit [salc_pkg::OFFSET_CFG_W-1:0]   cur_offset_bits;
   bit [salc_pkg::WAYS_CFG_W-1:0]     cur_ways = 1;
   logic [salc_pkg::OP_W-1:0]         access_kinds[3] = '{salc_pkg::OP_LOAD,
                                                          salc_pkg::OP_STORE,
                                                          salc_pkg::OP_MODIFY};

   set_assoc_lru_cache_classifier_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hits_now        (rsp_hits_now),
      .rsp_missed_now      (rsp_missed_now),
      .rsp_evicted_now     (rsp_evicted_now),
      .rsp_total_hits      (rsp_total_hits),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_total_evictions (rsp_total_evictions),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   initial begin
      int hold;
      bit level;
      hold = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if (quiet_phase) begin
               level = 1'b0;
               hold = 1;
            end else begin
               hold = pick_gap();
               level = (hold != 0);
               if (hold == 0) hold = $urandom_range(1, 6);
            end
         end
         rsp_stall <= level;
         hold--;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_outcome('{hits_now: rsp_hits_now, missed_now: rsp_missed_now,
                            evicted_now: rsp_evicted_now, total_hits: rsp_total_hits,
                            total_misses: rsp_total_misses,
                            total_evictions: rsp_total_evictions});
   end

   // one request, held until accepted
   task automatic send(logic [salc_pkg::OP_W-1:0] op, logic [63:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_op      <= op;
      req_address <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_access(op, addr);
      n_requests++;
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // write all registers once the block has drained
   task automatic configure(bit [salc_pkg::SET_CFG_W-1:0] s,
                            bit [salc_pkg::OFFSET_CFG_W-1:0] b,
                            bit [salc_pkg::WAYS_CFG_W-1:0] w);
      drop_request();
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= salc_pkg::CSR_SET_BITS;
      csr_wdata <= salc_pkg::CSR_DATA_W'(s);
      @(negedge clock);
      csr_index <= salc_pkg::CSR_OFFSET_BITS;
      csr_wdata <= salc_pkg::CSR_DATA_W'(b);
      @(negedge clock);
      csr_index <= salc_pkg::CSR_WAYS;
      csr_wdata <= salc_pkg::CSR_DATA_W'(w);
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_config(s, b, w);
      cur_set_bits    = s;
      cur_offset_bits = b;
      cur_ways        = w;
      n_settings++;
   endtask

   // tag | set | random offset
   function automatic logic [63:0] compose_address(int tag, int set, int es, int b);
      logic [63:0] off;
      off = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
      return (64'(tag) << (es + b)) | (64'(set) << b) | off;
   endfunction

   // address from a small pool of tags and sets so lines get reused
   function automatic logic [63:0] pick_address();
      int es, ew, nsets;
      es = (cur_set_bits > salc_scoreboard_pkg::TB_MAX_SET_BITS)
           ? salc_scoreboard_pkg::TB_MAX_SET_BITS : int'(cur_set_bits);
      ew = (cur_ways == 0) ? 1 : (cur_ways > salc_scoreboard_pkg::TB_MAX_WAYS)
           ? salc_scoreboard_pkg::TB_MAX_WAYS : int'(cur_ways);
      nsets = 1 << es;
      return compose_address($urandom_range(0, ew + 2),
                             $urandom_range(0, (nsets < 4 ? nsets : 4) - 1),
                             es, cur_offset_bits);
   endfunction

   function automatic bit [salc_pkg::OFFSET_CFG_W-1:0] pick_offset_bits();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return salc_pkg::OFFSET_CFG_W'($urandom_range(0, 8));
      if (r < 90) return salc_pkg::OFFSET_CFG_W'($urandom_range(9, 40));
      return salc_pkg::OFFSET_CFG_W'($urandom_range(41, 63));
   endfunction

   // run limit
   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int accesses;
      int r;
      sb = new();
      quiet_phase = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: one set, one way, no offset; unused op and address extremes
      send(salc_scoreboard_pkg::OP_NONE, '0);
      send(salc_pkg::OP_LOAD, '0);
      send(salc_pkg::OP_LOAD, '1);
      send(salc_pkg::OP_STORE, '1);
      send(salc_pkg::OP_MODIFY, '0);
      send(salc_scoreboard_pkg::OP_NONE, {$urandom, $urandom});

      // set bits past the limit, offset near the top, way count zero
      configure(3'd7, 6'd63, 4'd0);
      send(salc_pkg::OP_LOAD, '1);
      send(salc_pkg::OP_LOAD, '0);
      send(salc_pkg::OP_MODIFY, 64'd1 << 63);

      // set and offset fill the address so the tag is zero; way count past the limit
      configure(3'd6, 6'd58, 4'd15);
      send(salc_pkg::OP_LOAD, '1);
      send(salc_pkg::OP_MODIFY, '0);

      // equal ranks at eviction, then duplicate tags in one set
      configure(3'd2, 6'd4, 4'd3);
      send(salc_pkg::OP_LOAD, compose_address(1, 3, 2, 4));
      send(salc_pkg::OP_LOAD, compose_address(2, 3, 2, 4));
      send(salc_pkg::OP_STORE, compose_address(3, 3, 2, 4));
      configure(3'd2, 6'd4, 4'd2);
      send(salc_pkg::OP_LOAD, compose_address(2, 3, 2, 4));
      send(salc_pkg::OP_LOAD, compose_address(1, 3, 2, 4));
      configure(3'd2, 6'd4, 4'd1);
      send(salc_pkg::OP_LOAD, compose_address(1, 3, 2, 4));
      configure(3'd2, 6'd4, 4'd2);
      send(salc_pkg::OP_LOAD, compose_address(4, 3, 2, 4));
      configure(3'd2, 6'd4, 4'd1);
      send(salc_pkg::OP_LOAD, compose_address(3, 3, 2, 4));
      configure(3'd2, 6'd4, 4'd3);
      send(salc_pkg::OP_MODIFY, compose_address(3, 3, 2, 4));

      // random phases, each with its own cache geometry
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            configure(3'd6, 6'd0, 4'd8);
         else
            configure(salc_pkg::SET_CFG_W'($urandom_range(0, 7)), pick_offset_bits(),
                      salc_pkg::WAYS_CFG_W'($urandom_range(0, 15)));
         quiet_phase = (phase % 4 == 1);
         accesses = 0;
         while (accesses < PHASE_ACCESSES) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               send(salc_scoreboard_pkg::OP_NONE, {$urandom, $urandom});
            end else if (r < 18) begin
               send(access_kinds[$urandom_range(0, 2)], {$urandom, $urandom});
               accesses++;
            end else begin
               send(access_kinds[$urandom_range(0, 2)], pick_address());
               accesses++;
            end
         end
         quiet_phase = 1'b0;
      end

      // drain
      drop_request();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d cache geometries", n_requests, n_settings);
      $display("predicted totals: %0d hits, %0d misses, %0d evictions",
               sb.pred_hits, sb.pred_misses, sb.pred_evictions);
      if (sb.mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/set_assoc_lru_cache_classifier_unit.sv
tb/salc_scoreboard_pkg.sv
tb/tb.sv
